>>> hw/rtl/vev_pkg.sv
// ----------------------------------------------------------------------------
// vev_pkg: shared types and constants of the eddy viscosity core
// Holds the word formats of both channels, the internal widths of the
// datapath and the stage counts of the pipelined units.
// ----------------------------------------------------------------------------
package vev_pkg;

    // Input word: one mesh cell.
    typedef struct packed {
        logic signed [31:0] grad_xx;
        logic signed [31:0] grad_xy;
        logic signed [31:0] grad_xz;
        logic signed [31:0] grad_yx;
        logic signed [31:0] grad_yy;
        logic signed [31:0] grad_yz;
        logic signed [31:0] grad_zx;
        logic signed [31:0] grad_zy;
        logic signed [31:0] grad_zz;
        logic [31:0]        filter_width;
    } vev_in_t;

    // Result word.
    typedef struct packed {
        logic [31:0] eddy_viscosity;
        logic        saturated;
    } vev_out_t;

    // Internal widths.
    localparam int GW     = 64;   // entries of G and off-diagonal magnitudes
    localparam int NORM_W = 66;   // squared Frobenius norm, LSB 2^-32
    localparam int C25_W  = 69;   // 25 * c^4
    localparam int PROD_W = 128;  // 64 x 64 products
    localparam int BSUM_W = 130;  // sum of principal minors
    localparam int K_W    = PROD_W + C25_W;   // D^4 * 25 * c^4
    localparam int R_W    = BSUM_W + K_W;     // 25 * c^4 * D^4 * B
    localparam int NUM_W  = 168;  // dividend after alignment
    localparam int DEN_W  = NORM_W + 2;       // 4 * S
    localparam int QUO_W  = 64;   // quotient, wider values saturate
    localparam int ROOT_W = 32;   // result width

    // The norm sits 160 bits above the shared LSB of B.
    localparam int NORM_SHIFT = 160;

    // Stage counts.
    localparam int FRONT_LAT = 3;
    localparam int MUL_LAT   = 3;
    localparam int DIV_LAT   = QUO_W + 1;
    localparam int SQRT_LAT  = ROOT_W + 1;
    localparam int PIPE_LAT  = FRONT_LAT + 3 * MUL_LAT + 1 + DIV_LAT + SQRT_LAT + 1;

    // Front end results handed to the wide multipliers.
    typedef struct packed {
        logic [2:0][GW-1:0] g;
        logic [2:0][GW-1:0] off;
        logic [NORM_W-1:0]  norm;
        logic [GW-1:0]      d2;
        logic [C25_W-1:0]   c25;
    } vev_front_t;

endpackage

>>> hw/rtl/vreman_eddy_viscosity_core.sv
// ----------------------------------------------------------------------------
// vreman_eddy_viscosity_core: Vreman subgrid eddy viscosity, one cell a word
// Input words on s_* carry the nine gradient components and the filter
// width of a cell. Result words on m_* carry the eddy viscosity in unsigned
// Q0.32 and a flag that is set when the value was clamped to all ones.
// The model constant Cs is written on cfg_* (unsigned Q0.16); the port is
// always ready; the user must write it only while no cell is in flight,
// the block does not enforce this. A new word is taken every cycle while
// the skid register is empty. From acceptance a word passes three front-end
// stages, three chained wide multipliers of three stages each, an alignment
// stage, a 65-stage divider, a 33-stage square root and the output register.
// Reset clears the valid bits, the skid stage and sets Cs to its default.
// When the receiver stalls, the waiting result moves into a skid register
// and the whole pipeline holds until it is taken; no word is lost.
// ----------------------------------------------------------------------------
module vreman_eddy_viscosity_core
    import vev_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  vev_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output vev_out_t    m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    localparam int LATE_TAP = 3 * MUL_LAT - 1;
    localparam int K_TAP    = MUL_LAT - 1;

    logic              en;
    logic [15:0]       coeff_reg;
    logic              vld_reg [PIPE_LAT];
    vev_front_t        fr;

    logic [PROD_W-1:0] pg [3];
    logic [PROD_W-1:0] po [3];
    logic [PROD_W-1:0] d4;
    logic [K_W-1:0]    kprod;
    logic [R_W-1:0]    rprod;

    logic [BSUM_W-1:0] p_reg, q_reg;
    logic [BSUM_W-1:0] bsum_reg, bsum_d_reg;
    logic              d4z_reg [2];
    logic              zf_reg  [4];
    logic [C25_W-1:0]  c25_reg [3*MUL_LAT];
    logic [NORM_W-1:0] norm_reg [3*MUL_LAT];

    logic [R_W-1:0]    r_eff;
    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [QUO_W-1:0]  quo;
    logic              div_sat;
    logic [ROOT_W-1:0] root;
    logic              sq_sat;

    vev_out_t          out_reg;
    vev_out_t          skid_reg;
    logic              skid_valid_reg;

    // The pipeline moves as one while the skid register is empty.
    assign en        = !skid_valid_reg;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    // Model constant register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_reg <= 16'd6160;
        end else if (cfg_valid) begin
            coeff_reg <= cfg_data;
        end
    end

    // Valid bits travel alongside the data stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PIPE_LAT; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i < PIPE_LAT; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    vev_front u_front (
        .aclk  (aclk),
        .en    (en),
        .din   (s_data),
        .coeff (coeff_reg),
        .dout  (fr)
    );

    // Products for the principal minors and D^4.
    vev_mul #(.WA(GW), .WB(GW)) u_mul_g01 (
        .aclk(aclk), .en(en), .a(fr.g[0]), .b(fr.g[1]), .p(pg[0]));
    vev_mul #(.WA(GW), .WB(GW)) u_mul_g02 (
        .aclk(aclk), .en(en), .a(fr.g[0]), .b(fr.g[2]), .p(pg[1]));
    vev_mul #(.WA(GW), .WB(GW)) u_mul_g12 (
        .aclk(aclk), .en(en), .a(fr.g[1]), .b(fr.g[2]), .p(pg[2]));
    vev_mul #(.WA(GW), .WB(GW)) u_mul_o0 (
        .aclk(aclk), .en(en), .a(fr.off[0]), .b(fr.off[0]), .p(po[0]));
    vev_mul #(.WA(GW), .WB(GW)) u_mul_o1 (
        .aclk(aclk), .en(en), .a(fr.off[1]), .b(fr.off[1]), .p(po[1]));
    vev_mul #(.WA(GW), .WB(GW)) u_mul_o2 (
        .aclk(aclk), .en(en), .a(fr.off[2]), .b(fr.off[2]), .p(po[2]));
    vev_mul #(.WA(GW), .WB(GW)) u_mul_d4 (
        .aclk(aclk), .en(en), .a(fr.d2), .b(fr.d2), .p(d4));

    // Delay lines for the constant factor and the norm.
    always_ff @(posedge aclk) begin
        if (en) begin
            c25_reg[0]  <= fr.c25;
            norm_reg[0] <= fr.norm;
            for (int i = 1; i < 3*MUL_LAT; i++) begin
                c25_reg[i]  <= c25_reg[i-1];
                norm_reg[i] <= norm_reg[i-1];
            end
        end
    end

    // Sum of minors, clamped at zero, aligned with the constant product.
    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg      <= BSUM_W'(pg[0]) + BSUM_W'(pg[1]) + BSUM_W'(pg[2]);
            q_reg      <= BSUM_W'(po[0]) + BSUM_W'(po[1]) + BSUM_W'(po[2]);
            d4z_reg[0] <= (d4 == '0);
            d4z_reg[1] <= d4z_reg[0];
            bsum_reg   <= (p_reg >= q_reg) ? (p_reg - q_reg) : '0;
            bsum_d_reg <= bsum_reg;
            zf_reg[0]  <= (bsum_reg == '0) || d4z_reg[1];
            zf_reg[1]  <= zf_reg[0];
            zf_reg[2]  <= zf_reg[1];
            zf_reg[3]  <= zf_reg[2];
        end
    end

    vev_mul #(.WA(PROD_W), .WB(C25_W)) u_mul_k (
        .aclk(aclk), .en(en), .a(d4), .b(c25_reg[K_TAP]), .p(kprod));
    vev_mul #(.WA(BSUM_W), .WB(K_W)) u_mul_r (
        .aclk(aclk), .en(en), .a(bsum_d_reg), .b(kprod), .p(rprod));

    // Floor B to one LSB, then align dividend and divisor to the norm.
    assign r_eff = zf_reg[3] ? R_W'(c25_reg[LATE_TAP]) : rprod;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (norm_reg[LATE_TAP] == '0) begin
                num_reg <= NUM_W'(r_eff);
                den_reg <= DEN_W'(4);
            end else begin
                num_reg <= NUM_W'(r_eff >> NORM_SHIFT);
                den_reg <= {norm_reg[LATE_TAP], 2'b00};
            end
        end
    end

    vev_div u_div (
        .aclk (aclk),
        .en   (en),
        .num  (num_reg),
        .den  (den_reg),
        .quo  (quo),
        .sat  (div_sat)
    );

    vev_sqrt u_sqrt (
        .aclk    (aclk),
        .en      (en),
        .x       (quo),
        .sat_in  (div_sat),
        .root    (root),
        .sat_out (sq_sat)
    );

    // Output register with clamping.
    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg.eddy_viscosity <= sq_sat ? '1 : root;
            out_reg.saturated      <= sq_sat;
        end
    end

    // Skid register holds a result that the receiver did not take.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (vld_reg[PIPE_LAT-1] && !m_ready) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!skid_valid_reg) begin
            skid_reg <= out_reg;
        end
    end

    assign m_valid = skid_valid_reg || vld_reg[PIPE_LAT-1];
    assign m_data  = skid_valid_reg ? skid_reg : out_reg;

endmodule

>>> hw/rtl/vev_mul.sv
// ----------------------------------------------------------------------------
// vev_mul: pipelined wide unsigned multiplier
// Splits both operands into 32-bit limbs, registers the limb products,
// sums each row and then the rows, three stages in all.
// ----------------------------------------------------------------------------
module vev_mul
    import vev_pkg::*;
#(
    parameter int WA = 64,
    parameter int WB = 64
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WA-1:0]    a,
    input  logic [WB-1:0]    b,
    output logic [WA+WB-1:0] p
);
    localparam int NA = (WA + 31) / 32;
    localparam int NB = (WB + 31) / 32;
    localparam int RW = 32 * NB + 32;
    localparam int FW = 32 * (NA + NB);

    logic [32*NA-1:0] a_ext;
    logic [32*NB-1:0] b_ext;
    logic [63:0]      pp_reg [NA][NB];
    logic [RW-1:0]    row_next [NA];
    logic [RW-1:0]    row_reg  [NA];
    logic [FW-1:0]    prod_next;
    logic [FW-1:0]    prod_reg;

    assign a_ext = (32*NA)'(a);
    assign b_ext = (32*NB)'(b);

    // Row sums of the limb products.
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++) begin
                row_next[i] = row_next[i] + (RW'(pp_reg[i][j]) << (32 * j));
            end
        end
    end

    // Sum of the shifted rows.
    always_comb begin
        prod_next = '0;
        for (int i = 0; i < NA; i++) begin
            prod_next = prod_next + (FW'(row_reg[i]) << (32 * i));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    pp_reg[i][j] <= a_ext[32*i +: 32] * b_ext[32*j +: 32];
                end
                row_reg[i] <= row_next[i];
            end
            prod_reg <= prod_next;
        end
    end

    assign p = prod_reg[WA+WB-1:0];

endmodule

>>> hw/rtl/vev_front.sv
// ----------------------------------------------------------------------------
// vev_front: gradient products and sums
// Forms the entries of G = transpose(A) * A, the off-diagonal magnitudes,
// the squared norm, D^2 and 25 * Cs^4 over three stages.
// ----------------------------------------------------------------------------
module vev_front
    import vev_pkg::*;
(
    input  logic        aclk,
    input  logic        en,
    input  vev_in_t     din,
    input  logic [15:0] coeff,
    output vev_front_t  dout
);
    localparam int PI [3] = '{0, 0, 1};
    localparam int PJ [3] = '{1, 2, 2};

    logic signed [31:0] a [9];
    logic [31:0]        mag [9];

    logic [GW-1:0]      sq_reg  [9];
    logic [GW-1:0]      cr_reg  [9];
    logic               crn_reg [9];
    logic [GW-1:0]      d2_reg;
    logic [31:0]        c2_reg;

    logic [GW-1:0]      g_reg   [3];
    logic [GW-1:0]      pos_reg [3];
    logic [GW-1:0]      neg_reg [3];
    logic [NORM_W-1:0]  norm_reg;
    logic [GW-1:0]      c4_reg;
    logic [GW-1:0]      d2b_reg;

    logic [GW-1:0]      pos_next [3];
    logic [GW-1:0]      neg_next [3];
    logic [NORM_W-1:0]  norm_next;
    vev_front_t         out_next;
    vev_front_t         out_reg;

    assign a[0] = din.grad_xx;
    assign a[1] = din.grad_xy;
    assign a[2] = din.grad_xz;
    assign a[3] = din.grad_yx;
    assign a[4] = din.grad_yy;
    assign a[5] = din.grad_yz;
    assign a[6] = din.grad_zx;
    assign a[7] = din.grad_zy;
    assign a[8] = din.grad_zz;

    // Magnitudes of the gradient components.
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            mag[i] = a[i][31] ? (32'd0 - 32'(a[i])) : 32'(a[i]);
        end
    end

    // Stage one: squares, cross products with their signs, D^2 and Cs^2.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 9; i++) begin
                sq_reg[i] <= mag[i] * mag[i];
            end
            for (int n = 0; n < 3; n++) begin
                for (int k = 0; k < 3; k++) begin
                    cr_reg[3*n+k]  <= mag[3*k+PI[n]] * mag[3*k+PJ[n]];
                    crn_reg[3*n+k] <= a[3*k+PI[n]][31] ^ a[3*k+PJ[n]][31];
                end
            end
            d2_reg <= din.filter_width * din.filter_width;
            c2_reg <= coeff * coeff;
        end
    end

    // Stage two: the norm sum, cross terms split into positive and negative parts.
    always_comb begin
        norm_next = '0;
        for (int i = 0; i < 9; i++) begin
            norm_next = norm_next + NORM_W'(sq_reg[i]);
        end
        for (int n = 0; n < 3; n++) begin
            pos_next[n] = '0;
            neg_next[n] = '0;
            for (int k = 0; k < 3; k++) begin
                if (crn_reg[3*n+k]) begin
                    neg_next[n] = neg_next[n] + cr_reg[3*n+k];
                end else begin
                    pos_next[n] = pos_next[n] + cr_reg[3*n+k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                g_reg[i]   <= sq_reg[i] + sq_reg[3+i] + sq_reg[6+i];
                pos_reg[i] <= pos_next[i];
                neg_reg[i] <= neg_next[i];
            end
            norm_reg <= norm_next;
            c4_reg   <= c2_reg * c2_reg;
            d2b_reg  <= d2_reg;
        end
    end

    // Stage three: off-diagonal magnitudes and the factor 25 * Cs^4.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            out_next.g[i]   = g_reg[i];
            out_next.off[i] = (pos_reg[i] >= neg_reg[i]) ? (pos_reg[i] - neg_reg[i])
                                                         : (neg_reg[i] - pos_reg[i]);
        end
        out_next.norm = norm_reg;
        out_next.d2   = d2b_reg;
        out_next.c25  = (C25_W'(c4_reg) << 4) + (C25_W'(c4_reg) << 3) + C25_W'(c4_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign dout = out_reg;

endmodule

>>> hw/rtl/vev_div.sv
// ----------------------------------------------------------------------------
// vev_div: pipelined restoring divider
// Checks the quotient against its range, then develops one quotient bit
// per stage, most significant first.
// ----------------------------------------------------------------------------
module vev_div
    import vev_pkg::*;
(
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo,
    output logic             sat
);
    logic [NUM_W-1:0] rem_reg [QUO_W+1];
    logic [DEN_W-1:0] den_reg [QUO_W+1];
    logic [QUO_W-1:0] q_reg   [QUO_W+1];
    logic             sat_reg [QUO_W+1];

    // Entry stage: a quotient of 2^QUO_W or more saturates.
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            sat_reg[0] <= (num >= (NUM_W'(den) << QUO_W));
        end
    end

    // One quotient bit per stage.
    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        localparam int BITPOS = QUO_W - 1 - k;
        logic [NUM_W-1:0] shifted;
        assign shifted = NUM_W'(den_reg[k]) << BITPOS;

        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[k+1] <= den_reg[k];
                sat_reg[k+1] <= sat_reg[k];
                if (rem_reg[k] >= shifted) begin
                    rem_reg[k+1] <= rem_reg[k] - shifted;
                    q_reg[k+1]   <= q_reg[k] | (QUO_W'(1) << BITPOS);
                end else begin
                    rem_reg[k+1] <= rem_reg[k];
                    q_reg[k+1]   <= q_reg[k];
                end
            end
        end
    end

    assign quo = q_reg[QUO_W];
    assign sat = sat_reg[QUO_W];

endmodule

>>> hw/rtl/vev_sqrt.sv
// ----------------------------------------------------------------------------
// vev_sqrt: pipelined integer square root
// Digit-by-digit square root of the quotient, one result bit per stage,
// with the saturation flag carried alongside.
// ----------------------------------------------------------------------------
module vev_sqrt
    import vev_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [QUO_W-1:0]  x,
    input  logic              sat_in,
    output logic [ROOT_W-1:0] root,
    output logic              sat_out
);
    logic [QUO_W-1:0] num_reg [ROOT_W+1];
    logic [QUO_W-1:0] res_reg [ROOT_W+1];
    logic             sat_reg [ROOT_W+1];

    // Entry stage.
    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg[0] <= x;
            res_reg[0] <= '0;
            sat_reg[0] <= sat_in;
        end
    end

    // Each stage tries the next result bit against the remainder.
    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam logic [QUO_W-1:0] STEP = QUO_W'(1) << (2*ROOT_W - 2 - 2*k);
        logic [QUO_W:0] trial;
        assign trial = {1'b0, res_reg[k]} + {1'b0, STEP};

        always_ff @(posedge aclk) begin
            if (en) begin
                sat_reg[k+1] <= sat_reg[k];
                if ({1'b0, num_reg[k]} >= trial) begin
                    num_reg[k+1] <= num_reg[k] - trial[QUO_W-1:0];
                    res_reg[k+1] <= (res_reg[k] >> 1) + STEP;
                end else begin
                    num_reg[k+1] <= num_reg[k];
                    res_reg[k+1] <= res_reg[k] >> 1;
                end
            end
        end
    end

    assign root    = res_reg[ROOT_W][ROOT_W-1:0];
    assign sat_out = sat_reg[ROOT_W];

endmodule
